// ===== sv/frl_pkg.sv =====
// ----------------------------------------------------------------------------
// frl_pkg: shared definitions for the feedrate limit block
// Register indexes, winner codes, datapath widths and pipeline latencies.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SHARE_W  = 17;
  localparam int unsigned PERIOD_W = 16;

  localparam logic [SHARE_W-1:0]  SHARE_ONE     = 17'h10000;
  localparam logic [SHARE_W-1:0]  SHARE_RESET   = 17'd11796;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd1000;
  localparam logic [DATA_W-1:0]   AXIS_MAX_UNIT = 32'd30;
  // Two times microseconds per second, applied to the chord root.
  localparam logic [20:0]         CHORD_SCALE   = 21'd2000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VEL_MAX_X   = 3'd0,
    REG_VEL_MAX_Y   = 3'd1,
    REG_ACC_MAX_X   = 3'd2,
    REG_ACC_MAX_Y   = 3'd3,
    REG_ACCEL_SHARE = 3'd4,
    REG_PERIOD      = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WIN_CMD   = 2'd0,
    WIN_VEL   = 2'd1,
    WIN_CHORD = 2'd2,
    WIN_ACCEL = 2'd3
  } win_e;

  // Divider: 32-bit remainder, quotient width chosen per instance.
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned RAD_W  = 2 * ROOT_W;

  localparam int unsigned DIV32_LAT = 32 + 1;
  localparam int unsigned DIV64_LAT = 64 + 1;
  localparam int unsigned SQRT_LAT  = ROOT_W + 1;

  // Stage numbers: stage 1 holds the captured input transaction.
  localparam int unsigned S_AXIS  = 2 + DIV32_LAT;
  localparam int unsigned S_LV    = S_AXIS + 1;
  localparam int unsigned S_CSQ   = 3 + SQRT_LAT;
  localparam int unsigned S_CMUL  = S_CSQ + 1;
  localparam int unsigned S_CDIV  = S_CMUL + DIV32_LAT;
  localparam int unsigned S_LC    = S_CDIV + 1;
  localparam int unsigned S_ADIV  = 5 + DIV64_LAT;
  localparam int unsigned S_ALIGN = S_ADIV + SQRT_LAT;
  localparam int unsigned PIPE_LAT = S_ALIGN + 2;

endpackage

// ===== sv/feedrate_limit_min_of_four_top.sv =====
// ----------------------------------------------------------------------------
// feedrate_limit_min_of_four_top: feedrate limit, minimum of four limits
// Axis velocity, chord error and centripetal limits for one point, with the
// smallest of these and the commanded rate.
// ----------------------------------------------------------------------------
// Usage. A point is taken as a transaction at any rising edge where start is
// high and busy is low. busy is held low: the block is a fixed pipeline and
// takes a new point in every cycle. Each point gives exactly one result,
// shown for a single cycle with result_valid_o high. Results leave in the
// order points came in. Throughput is one point per cycle; the latency is
// set by the centripetal path: a 64-step divider followed by a 32-step
// square root, one bit per stage, with five stages of capture, multiplies
// and the wide sum ahead of them and two final stages for the minimum and
// the result registers.
// The receiver cannot stall the block, so results are never held back.
// Configuration writes use their own valid/ready channel, always ready, and
// should be made only while no point is in flight.
// Reset, asynchronous and active low, clears the valid bits of every stage
// and returns the limits registers to their default values.
// ----------------------------------------------------------------------------
module feedrate_limit_min_of_four_top #(
  parameter int unsigned FRAC_BITS = frl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [frl_pkg::DATA_W-1:0]    command_rate_i,
  input  logic [frl_pkg::DATA_W-1:0]    curvature_radius_i,
  input  logic [frl_pkg::DATA_W-1:0]    chord_error_i,
  input  logic signed [frl_pkg::DATA_W-1:0] vel_x_i,
  input  logic signed [frl_pkg::DATA_W-1:0] vel_y_i,
  input  logic [frl_pkg::DATA_W-1:0]    vel_mag_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [frl_pkg::DATA_W-1:0]    cfg_data_i,
  output logic                          result_valid_o,
  output logic [frl_pkg::DATA_W-1:0]    rate_limit_o,
  output logic [frl_pkg::DATA_W-1:0]    limit_velocity_o,
  output logic [frl_pkg::DATA_W-1:0]    limit_chord_o,
  output logic [frl_pkg::DATA_W-1:0]    limit_accel_o,
  output logic [1:0]                    winner_o,
  output logic                          radicand_negative_o
);
  import frl_pkg::*;

  localparam int unsigned D_CMD = S_ALIGN - 1;
  localparam int unsigned D_LV  = S_ALIGN - S_LV;
  localparam int unsigned D_NEG = S_CDIV - 2;
  localparam int unsigned D_LC  = S_ALIGN - S_LC;

  // ---- Configuration registers -------------------------------------------
  logic [DATA_W-1:0]   vmax_x_q, vmax_y_q, amax_x_q, amax_y_q;
  logic [SHARE_W-1:0]  share_q;
  logic [PERIOD_W-1:0] period_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_x_q <= AXIS_MAX_UNIT << FRAC_BITS;
      vmax_y_q <= AXIS_MAX_UNIT << FRAC_BITS;
      amax_x_q <= AXIS_MAX_UNIT << FRAC_BITS;
      amax_y_q <= AXIS_MAX_UNIT << FRAC_BITS;
      share_q  <= SHARE_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VEL_MAX_X:   vmax_x_q <= cfg_data_i;
        REG_VEL_MAX_Y:   vmax_y_q <= cfg_data_i;
        REG_ACC_MAX_X:   amax_x_q <= cfg_data_i;
        REG_ACC_MAX_Y:   amax_y_q <= cfg_data_i;
        REG_ACCEL_SHARE: share_q  <= cfg_data_i[SHARE_W-1:0];
        REG_PERIOD:      period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- Valid bits, one per stage -----------------------------------------
  logic                accept;
  logic [PIPE_LAT:1]   vld_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-1:1], accept};
    end
  end

  // ---- Stage 1: capture, axis magnitudes, share clamp --------------------
  logic [DATA_W-1:0]  cmd_s1_q, rho_s1_q, eps_s1_q, ax_s1_q, ay_s1_q, spd_s1_q;
  logic [SHARE_W-1:0] lam_s1_q;

  always_ff @(posedge clk_i) begin
    cmd_s1_q <= command_rate_i;
    rho_s1_q <= curvature_radius_i;
    eps_s1_q <= chord_error_i;
    // The most negative component wraps to 2^31, which is its magnitude.
    ax_s1_q  <= vel_x_i[DATA_W-1] ? DATA_W'(-vel_x_i) : DATA_W'(vel_x_i);
    ay_s1_q  <= vel_y_i[DATA_W-1] ? DATA_W'(-vel_y_i) : DATA_W'(vel_y_i);
    spd_s1_q <= vel_mag_i;
    lam_s1_q <= (share_q > SHARE_ONE) ? SHARE_ONE : share_q;
  end

  // ---- Stage 2: first products and the radicand sign ---------------------
  logic [2*DATA_W-1:0] pvx_s2_q, pvy_s2_q, re_s2_q, ee_s2_q;
  logic [DATA_W-1:0]   lr_s2_q, ax_s2_q, ay_s2_q, spd_s2_q;
  logic                neg_s2_q;
  logic [SHARE_W+DATA_W-1:0] lr_full;
  logic [2*DATA_W-1:0]       rho_sh;

  // lambda never exceeds one, so lambda*rho/2^16 stays within 32 bits.
  assign lr_full = (SHARE_W+DATA_W)'(lam_s1_q) * (SHARE_W+DATA_W)'(rho_s1_q);
  assign rho_sh  = {{DATA_W{1'b0}}, rho_s1_q} << (33 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    pvx_s2_q <= (2*DATA_W)'(vmax_x_q) * (2*DATA_W)'(spd_s1_q);
    pvy_s2_q <= (2*DATA_W)'(vmax_y_q) * (2*DATA_W)'(spd_s1_q);
    re_s2_q  <= (2*DATA_W)'(rho_s1_q) * (2*DATA_W)'(eps_s1_q);
    ee_s2_q  <= (2*DATA_W)'(eps_s1_q) * (2*DATA_W)'(eps_s1_q);
    lr_s2_q  <= lr_full[DATA_W+15:16];
    neg_s2_q <= {{DATA_W{1'b0}}, eps_s1_q} > rho_sh;
    ax_s2_q  <= ax_s1_q;
    ay_s2_q  <= ay_s1_q;
    spd_s2_q <= spd_s1_q;
  end

  // ---- Axis velocity limit -----------------------------------------------
  logic [DATA_W-1:0] axv_x, axv_y, lv_q, lv_al;

  frl_div #(.QW(DATA_W)) u_div_vx (
    .clk_i    (clk_i),
    .num_hi_i (pvx_s2_q[2*DATA_W-1:DATA_W]),
    .num_lo_i (pvx_s2_q[DATA_W-1:0]),
    .den_i    (ax_s2_q),
    .quot_o   (axv_x)
  );

  frl_div #(.QW(DATA_W)) u_div_vy (
    .clk_i    (clk_i),
    .num_hi_i (pvy_s2_q[2*DATA_W-1:DATA_W]),
    .num_lo_i (pvy_s2_q[DATA_W-1:0]),
    .den_i    (ay_s2_q),
    .quot_o   (axv_y)
  );

  always_ff @(posedge clk_i) begin
    lv_q <= (axv_x < axv_y) ? axv_x : axv_y;
  end

  frl_delay #(.W(DATA_W), .DEPTH(D_LV)) u_dly_lv (
    .clk_i (clk_i), .d_i (lv_q), .q_o (lv_al)
  );

  // ---- Stage 3: chord radicand and centripetal acceleration products -----
  logic [2*DATA_W-1:0] rad_s3_q, mx_s3_q, my_s3_q;
  logic [DATA_W-1:0]   ax_s3_q, ay_s3_q, spd_s3_q;
  logic [2*DATA_W-1:0] p_term, e2_term;

  assign p_term  = re_s2_q >> (31 - FRAC_BITS);
  assign e2_term = ee_s2_q >> (64 - 2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    rad_s3_q <= (p_term > e2_term) ? (p_term - e2_term) : '0;
    mx_s3_q  <= (2*DATA_W)'(lr_s2_q) * (2*DATA_W)'(amax_x_q);
    my_s3_q  <= (2*DATA_W)'(lr_s2_q) * (2*DATA_W)'(amax_y_q);
    ax_s3_q  <= ax_s2_q;
    ay_s3_q  <= ay_s2_q;
    spd_s3_q <= spd_s2_q;
  end

  // ---- Chord error limit -------------------------------------------------
  logic [ROOT_W-1:0]   chord_root;
  logic [2*DATA_W-1:0] cp_q;
  logic [DATA_W-1:0]   chord_quot, lc_q, lc_al;
  logic                neg_cd, neg_al;

  frl_sqrt u_sqrt_chord (
    .clk_i  (clk_i),
    .rad_i  (rad_s3_q),
    .root_o (chord_root)
  );

  always_ff @(posedge clk_i) begin
    cp_q <= (2*DATA_W)'(chord_root) * (2*DATA_W)'(CHORD_SCALE);
  end

  // A zero period makes the divider saturate, as it should.
  frl_div #(.QW(DATA_W)) u_div_chord (
    .clk_i    (clk_i),
    .num_hi_i (cp_q[2*DATA_W-1:DATA_W]),
    .num_lo_i (cp_q[DATA_W-1:0]),
    .den_i    ({{(DATA_W-PERIOD_W){1'b0}}, period_q}),
    .quot_o   (chord_quot)
  );

  frl_delay #(.W(1), .DEPTH(D_NEG)) u_dly_neg_cd (
    .clk_i (clk_i), .d_i (neg_s2_q), .q_o (neg_cd)
  );

  always_ff @(posedge clk_i) begin
    lc_q <= neg_cd ? '0 : chord_quot;
  end

  frl_delay #(.W(DATA_W), .DEPTH(D_LC)) u_dly_lc (
    .clk_i (clk_i), .d_i (lc_q), .q_o (lc_al)
  );

  frl_delay #(.W(1), .DEPTH(D_LC + 1)) u_dly_neg_al (
    .clk_i (clk_i), .d_i (neg_cd), .q_o (neg_al)
  );

  // ---- Stages 4 and 5: 96-bit products for the centripetal quotients -----
  logic [2*DATA_W-1:0] mx_lo_s4_q, mx_hi_s4_q, my_lo_s4_q, my_hi_s4_q;
  logic [DATA_W-1:0]   ax_s4_q, ay_s4_q, ax_s5_q, ay_s5_q;
  logic [3*DATA_W-1:0] px_s5_q, py_s5_q;

  always_ff @(posedge clk_i) begin
    mx_lo_s4_q <= (2*DATA_W)'(mx_s3_q[DATA_W-1:0]) * (2*DATA_W)'(spd_s3_q);
    mx_hi_s4_q <= (2*DATA_W)'(mx_s3_q[2*DATA_W-1:DATA_W]) * (2*DATA_W)'(spd_s3_q);
    my_lo_s4_q <= (2*DATA_W)'(my_s3_q[DATA_W-1:0]) * (2*DATA_W)'(spd_s3_q);
    my_hi_s4_q <= (2*DATA_W)'(my_s3_q[2*DATA_W-1:DATA_W]) * (2*DATA_W)'(spd_s3_q);
    ax_s4_q    <= ax_s3_q;
    ay_s4_q    <= ay_s3_q;
    px_s5_q    <= {mx_hi_s4_q, {DATA_W{1'b0}}} + {{DATA_W{1'b0}}, mx_lo_s4_q};
    py_s5_q    <= {my_hi_s4_q, {DATA_W{1'b0}}} + {{DATA_W{1'b0}}, my_lo_s4_q};
    ax_s5_q    <= ax_s4_q;
    ay_s5_q    <= ay_s4_q;
  end

  // ---- Centripetal limit -------------------------------------------------
  // The x acceleration pairs with |vy| and the y acceleration with |vx|.
  // An overflowing quotient reads as all ones, whose root is already the
  // saturated limit.
  logic [2*DATA_W-1:0] cq_a, cq_b;
  logic [ROOT_W-1:0]   la_a, la_b;

  frl_div #(.QW(2*DATA_W)) u_div_ax (
    .clk_i    (clk_i),
    .num_hi_i (px_s5_q[3*DATA_W-1:2*DATA_W]),
    .num_lo_i (px_s5_q[2*DATA_W-1:0]),
    .den_i    (ay_s5_q),
    .quot_o   (cq_a)
  );

  frl_div #(.QW(2*DATA_W)) u_div_ay (
    .clk_i    (clk_i),
    .num_hi_i (py_s5_q[3*DATA_W-1:2*DATA_W]),
    .num_lo_i (py_s5_q[2*DATA_W-1:0]),
    .den_i    (ax_s5_q),
    .quot_o   (cq_b)
  );

  frl_sqrt u_sqrt_ax (.clk_i (clk_i), .rad_i (cq_a), .root_o (la_a));
  frl_sqrt u_sqrt_ay (.clk_i (clk_i), .rad_i (cq_b), .root_o (la_b));

  // ---- Commanded rate, carried to the final stages -----------------------
  logic [DATA_W-1:0] cmd_al;

  frl_delay #(.W(DATA_W), .DEPTH(D_CMD)) u_dly_cmd (
    .clk_i (clk_i), .d_i (cmd_s1_q), .q_o (cmd_al)
  );

  // ---- Final two stages: minimum of four and result registers ------------
  logic [DATA_W-1:0] cmd_f_q, lv_f_q, lc_f_q, la_f_q;
  logic              neg_f_q;
  logic [DATA_W-1:0] best;
  win_e              win;

  always_ff @(posedge clk_i) begin
    cmd_f_q <= cmd_al;
    lv_f_q  <= lv_al;
    lc_f_q  <= lc_al;
    la_f_q  <= (la_a < la_b) ? la_a : la_b;
    neg_f_q <= neg_al;
  end

  // Strict compares keep the lowest index on a tie.
  always_comb begin
    best = cmd_f_q;
    win  = WIN_CMD;
    if (lv_f_q < best) begin
      best = lv_f_q;
      win  = WIN_VEL;
    end
    if (lc_f_q < best) begin
      best = lc_f_q;
      win  = WIN_CHORD;
    end
    if (la_f_q < best) begin
      best = la_f_q;
      win  = WIN_ACCEL;
    end
  end

  logic [DATA_W-1:0] rate_q, lvel_q, lchord_q, laccel_q;
  win_e              win_q;
  logic              neg_q;

  always_ff @(posedge clk_i) begin
    rate_q   <= best;
    lvel_q   <= lv_f_q;
    lchord_q <= lc_f_q;
    laccel_q <= la_f_q;
    win_q    <= win;
    neg_q    <= neg_f_q;
  end

  assign result_valid_o      = vld_q[PIPE_LAT];
  assign rate_limit_o        = rate_q;
  assign limit_velocity_o    = lvel_q;
  assign limit_chord_o       = lchord_q;
  assign limit_accel_o       = laccel_q;
  assign winner_o            = win_q;
  assign radicand_negative_o = neg_q;

endmodule

// ===== sv/frl_div.sv =====
// ----------------------------------------------------------------------------
// frl_div: pipelined saturating divider
// Divides {num_hi, num_lo} by den, one quotient bit per stage; returns all
// ones when the quotient does not fit in QW bits or den is zero.
// ----------------------------------------------------------------------------
module frl_div #(
  parameter int unsigned QW = 32
) (
  input  logic                      clk_i,
  input  logic [frl_pkg::DIV_W-1:0] num_hi_i,
  input  logic [QW-1:0]             num_lo_i,
  input  logic [frl_pkg::DIV_W-1:0] den_i,
  output logic [QW-1:0]             quot_o
);
  import frl_pkg::*;

  logic [DIV_W-1:0] rem_q [0:QW-1];
  logic [QW-1:0]    acc_q [0:QW];
  logic [DIV_W-1:0] den_q [0:QW-1];
  logic             sat_q [0:QW];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_hi_i;
    acc_q[0] <= num_lo_i;
    den_q[0] <= den_i;
    sat_q[0] <= (num_hi_i >= den_i);
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    assign trial = {rem_q[s-1], acc_q[s-1][QW-1]};
    assign diff  = trial - {1'b0, den_q[s-1]};
    always_ff @(posedge clk_i) begin
      sat_q[s] <= sat_q[s-1];
      if (!diff[DIV_W]) begin
        acc_q[s] <= {acc_q[s-1][QW-2:0], 1'b1};
      end else begin
        acc_q[s] <= {acc_q[s-1][QW-2:0], 1'b0};
      end
    end
    // The last stage only needs its quotient bit.
    if (s < QW) begin : g_pass
      always_ff @(posedge clk_i) begin
        den_q[s] <= den_q[s-1];
        if (!diff[DIV_W]) begin
          rem_q[s] <= diff[DIV_W-1:0];
        end else begin
          rem_q[s] <= trial[DIV_W-1:0];
        end
      end
    end
  end

  assign quot_o = sat_q[QW] ? {QW{1'b1}} : acc_q[QW];

endmodule

// ===== sv/frl_sqrt.sv =====
// ----------------------------------------------------------------------------
// frl_sqrt: pipelined integer square root
// Floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module frl_sqrt (
  input  logic                       clk_i,
  input  logic [frl_pkg::RAD_W-1:0]  rad_i,
  output logic [frl_pkg::ROOT_W-1:0] root_o
);
  import frl_pkg::*;

  logic [RAD_W-1:0]    rad_q  [0:ROOT_W-1];
  logic [ROOT_W+1:0]   rem_q  [0:ROOT_W-1];
  logic [ROOT_W-1:0]   root_q [0:ROOT_W];

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= rad_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_step
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    assign cur   = {rem_q[s-1], rad_q[s-1][RAD_W-1 -: 2]};
    assign trial = {2'b00, root_q[s-1], 2'b01};
    always_ff @(posedge clk_i) begin
      if (cur >= trial) begin
        root_q[s] <= {root_q[s-1][ROOT_W-2:0], 1'b1};
      end else begin
        root_q[s] <= {root_q[s-1][ROOT_W-2:0], 1'b0};
      end
    end
    // The last stage only needs its root bit.
    if (s < ROOT_W) begin : g_pass
      logic [ROOT_W+3:0] diff;
      assign diff = cur - trial;
      always_ff @(posedge clk_i) begin
        rad_q[s] <= {rad_q[s-1][RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[s] <= diff[ROOT_W+1:0];
        end else begin
          rem_q[s] <= cur[ROOT_W+1:0];
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W];

endmodule

// ===== sv/frl_delay.sv =====
// ----------------------------------------------------------------------------
// frl_delay: register delay line
// Carries a value through its register chain to line it up with a longer path.
// ----------------------------------------------------------------------------
module frl_delay #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== sv/frl_checker.sv =====
// ----------------------------------------------------------------------------
// frl_checker: port-level checks for the feedrate limit block
// Watches results against accepted transactions, the minimum selection and
// the zero chord limit on a negative radicand.
module frl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic [frl_pkg::DATA_W-1:0]    rate_limit_o,
  input logic [frl_pkg::DATA_W-1:0]    limit_velocity_o,
  input logic [frl_pkg::DATA_W-1:0]    limit_chord_o,
  input logic [frl_pkg::DATA_W-1:0]    limit_accel_o,
  input logic [1:0]                    winner_o,
  input logic                          radicand_negative_o
);
  import frl_pkg::*;

  // Every result stems from an earlier accepted transaction.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching transaction");

  a_rate_is_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rate_limit_o <= limit_velocity_o) &&
                       (rate_limit_o <= limit_chord_o) &&
                       (rate_limit_o <= limit_accel_o))
    else $error("rate limit above one of the computed limits");

  a_winner_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (winner_o == WIN_VEL   && rate_limit_o == limit_velocity_o) ||
      (winner_o == WIN_CHORD && rate_limit_o == limit_chord_o) ||
      (winner_o == WIN_ACCEL && rate_limit_o == limit_accel_o) ||
      (winner_o == WIN_CMD))
    else $error("winner does not name the selected limit");

  a_neg_chord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && radicand_negative_o |-> limit_chord_o == '0)
    else $error("negative radicand with nonzero chord limit");

endmodule

bind feedrate_limit_min_of_four_top frl_checker u_frl_checker (.*);
